[hdl/dnup_pkg.sv]
package dnup_pkg;

    // Characters with a meaning of their own in a path.
    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_AT     = 8'h40;

    localparam logic [63:0] NAME_SPACES = {8{CH_SPACE}};
    localparam logic [23:0] TYPE_SPACES = {3{CH_SPACE}};

    localparam logic [7:0] USER_MAX = 8'd15;

    // Classification of one path byte.
    typedef struct packed {
        logic       is_letter;
        logic       is_digit;
        logic       printable;
        logic [7:0] upper;
    } t_char_class;

endpackage

[hdl/drive_name_type_user_path_parser.sv]
// Result: the result of a path is registered on the output register when the
// terminating zero byte is accepted; all other bytes produce no result.
// Throughput: one path byte per cycle while the input side is not stalled.
// While a result waits and the receiver stalls, the input side stalls as well, so
// bytes flow only when the output register is empty or is being taken.
// Reset: synchronous, active low; the parser returns to the start of a path with
// space-filled name and type and no result pending.
module drive_name_type_user_path_parser
    import dnup_pkg::*;
#(
    parameter int NAME_LENGTH = 8,
    parameter int TYPE_LENGTH = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_code,

    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_ok,
    output logic [4:0]  o_drive_number,
    output logic [63:0] o_name_chars,
    output logic [23:0] o_type_chars,
    output logic [3:0]  o_user_number
);

    // Parser phases. The held phase keeps a leading letter until the following
    // byte tells whether it is a drive letter or the first name character.
    typedef enum logic [2:0] {
        PH_START,
        PH_HELD,
        PH_NAME,
        PH_TYPE,
        PH_UFIRST,
        PH_UDIGIT,
        PH_CLOSED,
        PH_ERROR
    } t_phase;

    t_phase      r_phase,         n_phase;
    logic [7:0]  r_held_letter,   n_held_letter;
    logic [3:0]  r_char_position, n_char_position;
    logic [63:0] r_name_store,    n_name_store;
    logic [23:0] r_type_store,    n_type_store;
    logic [4:0]  r_drive_store,   n_drive_store;
    logic [3:0]  r_user_store,    n_user_store;

    logic        r_out_valid;
    logic        r_out_ok;
    logic [4:0]  r_out_drive;
    logic [63:0] r_out_name;
    logic [23:0] r_out_type;
    logic [3:0]  r_out_user;

    logic        in_accept;
    logic        is_end;
    t_char_class cur_class;
    t_char_class held_class;

    // Name step signals: a single name unit serves the start phase, the plain name phase and
    // the case where a held letter turns out to be the first name character.
    logic [63:0] nm_base;
    logic [3:0]  nm_pos;
    logic [2:0]  nm_byte_sel;
    logic [63:0] nm_written;
    t_phase      nm_phase;
    logic [63:0] nm_store;
    logic [3:0]  nm_new_pos;

    logic [1:0]  ty_byte_sel;
    logic [23:0] ty_written;
    logic [7:0]  user_sum;

    dnup_char_class u_cur_class (
        .i_char  (i_char_code),
        .o_class (cur_class)
    );

    dnup_char_class u_held_class (
        .i_char  (r_held_letter),
        .o_class (held_class)
    );

    // The input side waits only when a finished result is still not taken.
    assign o_stall   = r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;
    assign is_end    = (i_char_code == CH_END);

    // Name byte handling. In the held phase the held letter is placed here
    // into the top name byte, so the current byte lands in position one.
    always_comb begin
        if (r_phase == PH_HELD) begin
            nm_base         = r_name_store;
            nm_base[63:56]  = held_class.upper;
            nm_pos          = 4'd1;
        end else begin
            nm_base = r_name_store;
            nm_pos  = r_char_position;
        end
        nm_byte_sel = 3'd7 - nm_pos[2:0];
        nm_written  = nm_base;
        nm_written[{nm_byte_sel, 3'b000} +: 8] = cur_class.upper;

        if (i_char_code == CH_DOT) begin
            nm_phase   = (nm_pos == 4'd0) ? PH_ERROR : PH_TYPE;
            nm_store   = nm_base;
            nm_new_pos = 4'd0;
        end else if ((i_char_code == CH_LBRACK) || (nm_pos >= 4'(NAME_LENGTH))
                     || !cur_class.printable) begin
            nm_phase   = PH_ERROR;
            nm_store   = nm_base;
            nm_new_pos = nm_pos;
        end else begin
            nm_phase   = PH_NAME;
            nm_store   = nm_written;
            nm_new_pos = nm_pos + 4'd1;
        end
    end

    // Type byte placement: the first type byte goes to the top of the field.
    always_comb begin
        ty_byte_sel = 2'd2 - r_char_position[1:0];
        ty_written  = r_type_store;
        ty_written[{ty_byte_sel, 3'b000} +: 8] = cur_class.upper;
    end

    // Running user number: times ten plus the new digit; at most 159 here.
    assign user_sum = {1'b0, r_user_store, 3'b000} + {3'b000, r_user_store, 1'b0}
                      + {4'b0000, i_char_code[3:0]};

    // Next parser state for one accepted non-zero byte.
    always_comb begin
        n_phase         = r_phase;
        n_held_letter   = r_held_letter;
        n_char_position = r_char_position;
        n_name_store    = r_name_store;
        n_type_store    = r_type_store;
        n_drive_store   = r_drive_store;
        n_user_store    = r_user_store;

        case (r_phase)
            PH_START: begin
                if (cur_class.is_letter) begin
                    n_held_letter = i_char_code;
                    n_phase       = PH_HELD;
                end else begin
                    n_phase         = nm_phase;
                    n_name_store    = nm_store;
                    n_char_position = nm_new_pos;
                end
            end
            PH_HELD: begin
                if (i_char_code == CH_COLON) begin
                    n_drive_store = 5'(held_class.upper - CH_AT);
                    n_phase       = PH_NAME;
                end else begin
                    n_phase         = nm_phase;
                    n_name_store    = nm_store;
                    n_char_position = nm_new_pos;
                end
                n_held_letter = '0;
            end
            PH_NAME: begin
                n_phase         = nm_phase;
                n_name_store    = nm_store;
                n_char_position = nm_new_pos;
            end
            PH_TYPE: begin
                if (i_char_code == CH_LBRACK) begin
                    n_phase = (r_char_position == 4'd0) ? PH_ERROR : PH_UFIRST;
                end else if ((r_char_position >= 4'(TYPE_LENGTH))
                             || !cur_class.printable) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_type_store    = ty_written;
                    n_char_position = r_char_position + 4'd1;
                end
            end
            PH_UFIRST: begin
                if (cur_class.is_digit) begin
                    n_user_store = i_char_code[3:0];
                    n_phase      = PH_UDIGIT;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_UDIGIT: begin
                if (cur_class.is_digit) begin
                    if (user_sum > USER_MAX) begin
                        n_phase = PH_ERROR;
                    end else begin
                        n_user_store = user_sum[3:0];
                    end
                end else if (i_char_code == CH_RBRACK) begin
                    n_phase = PH_CLOSED;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_CLOSED: begin
                // Nothing may follow the closing bracket but the end byte.
                n_phase = PH_ERROR;
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase
    end

    // Parser state. The end byte returns everything to the start of a path.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_accept && is_end)) begin
            r_phase         <= PH_START;
            r_held_letter   <= '0;
            r_char_position <= '0;
            r_name_store    <= NAME_SPACES;
            r_type_store    <= TYPE_SPACES;
            r_drive_store   <= '0;
            r_user_store    <= '0;
        end else if (in_accept) begin
            r_phase         <= n_phase;
            r_held_letter   <= n_held_letter;
            r_char_position <= n_char_position;
            r_name_store    <= n_name_store;
            r_type_store    <= n_type_store;
            r_drive_store   <= n_drive_store;
            r_user_store    <= n_user_store;
        end
    end

    // Result register. Only a path that reached the closing bracket is good;
    // a failed path reports all fields as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && is_end) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && is_end) begin
            r_out_ok    <= (r_phase == PH_CLOSED);
            r_out_drive <= (r_phase == PH_CLOSED) ? r_drive_store : '0;
            r_out_name  <= (r_phase == PH_CLOSED) ? r_name_store  : '0;
            r_out_type  <= (r_phase == PH_CLOSED) ? r_type_store  : '0;
            r_out_user  <= (r_phase == PH_CLOSED) ? r_user_store  : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_ok           = r_out_ok;
    assign o_drive_number = r_out_drive;
    assign o_name_chars   = r_out_name;
    assign o_type_chars   = r_out_type;
    assign o_user_number  = r_out_user;

`ifndef ASSERT_OFF
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_drive_number == 5'd0 && o_name_chars == 64'd0
                                && o_type_chars == 24'd0 && o_user_number == 4'd0))
        else $error("failed path reported nonzero fields");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ok) |-> (o_drive_number <= 5'd26))
        else $error("drive number out of range");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_end) |=> (r_phase == PH_START && r_char_position == 4'd0
                                    && r_out_valid))
        else $error("end byte did not restart parser and post a result");

    a_type_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_TYPE) |-> (r_char_position <= 4'(TYPE_LENGTH)))
        else $error("type position past type length");

    a_name_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NAME) |-> (r_char_position <= 4'(NAME_LENGTH)))
        else $error("name position past name length");
`endif

endmodule

[hdl/dnup_char_class.sv]
module dnup_char_class
    import dnup_pkg::*;
(
    input  logic [7:0]  i_char,
    output t_char_class o_class
);

    logic is_lower;
    logic is_upper;

    assign is_lower = (i_char >= 8'h61) && (i_char <= 8'h7a);
    assign is_upper = (i_char >= 8'h41) && (i_char <= 8'h5a);

    always_comb begin
        o_class.is_letter = is_lower || is_upper;
        o_class.is_digit  = (i_char >= 8'h30) && (i_char <= 8'h39);
        o_class.printable = (i_char > 8'h20) && (i_char < 8'h7f);
        o_class.upper     = is_lower ? (i_char - 8'h20) : i_char;
    end

endmodule
